// ===== design/rrpm_pkg.sv =====
// ----------------------------------------------------------------------------
// rrpm_pkg: shared definitions for the round-robin polled memory port
// Sizes, field widths and the acknowledge phase type used by the block.
// ----------------------------------------------------------------------------
package rrpm_pkg;

	localparam int unsigned REQUESTER_COUNT = 5;
	localparam int unsigned STORE_WORDS     = 1024;
	localparam int unsigned POLL_WINDOW     = 3;

	localparam int unsigned REQ_W   = 5;
	localparam int unsigned ADDR_W  = 16;
	localparam int unsigned DATA_W  = 64;
	localparam int unsigned GRANT_W = 3;

	localparam int unsigned PTR_W  = (REQUESTER_COUNT > 1) ? $clog2(REQUESTER_COUNT) : 1;
	localparam int unsigned WIN_W  = $clog2(POLL_WINDOW + 1);
	localparam int unsigned MEM_AW = $clog2(STORE_WORDS);

	typedef enum logic [1:0] {
		PHASE_IDLE,
		PHASE_READ,
		PHASE_WRITE
	} phase_t;

endpackage

// ===== design/rrpm_if.sv =====
// ----------------------------------------------------------------------------
// rrpm_if: request and response channels of the polled memory port
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface rrpm_req_if import rrpm_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [REQ_W-1:0]  read_requests;
	logic [REQ_W-1:0]  write_requests;
	logic [ADDR_W-1:0] address;
	logic [DATA_W-1:0] write_data;

	modport source (output valid, read_requests, write_requests, address, write_data,
		input ready);
	modport sink (input valid, read_requests, write_requests, address, write_data,
		output ready);
endinterface

interface rrpm_rsp_if import rrpm_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               grant_valid;
	logic [GRANT_W-1:0] grant_index;
	logic               read_ack;
	logic               write_ack;
	logic [DATA_W-1:0]  read_data;

	modport source (output valid, grant_valid, grant_index, read_ack, write_ack, read_data,
		input ready);
	modport sink (input valid, grant_valid, grant_index, read_ack, write_ack, read_data,
		output ready);
endinterface

// ===== design/rrpm_word_ram.sv =====
// ----------------------------------------------------------------------------
// rrpm_word_ram: single-port word store
// One access per cycle, synchronous write, registered read data.
// ----------------------------------------------------------------------------
module rrpm_word_ram import rrpm_pkg::*; (
	input  logic              clk,
	input  logic              we,
	input  logic              re,
	input  logic [MEM_AW-1:0] addr,
	input  logic [DATA_W-1:0] wdata,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [STORE_WORDS];
	logic [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== design/round_robin_polled_memory_port.sv =====
// ----------------------------------------------------------------------------
// round_robin_polled_memory_port: shared word memory polled in round-robin turn
// A tick's response beat passes through stage 1 and then the output register.
// Throughput: one tick per cycle while the response channel is ready; the
// single-port word RAM sees at most one access per tick, and stage 1 waits for its registered read data.
// Reset (arst_n, asynchronous): pointer, window count, phase and both valid flags clear to zero/idle.
// The word store is not cleared; a word reads back only after it was written.
// ----------------------------------------------------------------------------
module round_robin_polled_memory_port import rrpm_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	rrpm_req_if.sink req_ch,
	rrpm_rsp_if.source rsp_ch
);

	// Arbitration state. Each request beat is one bus tick.
	logic [PTR_W-1:0] ptr_q, ptr_d;
	logic [WIN_W-1:0] window_q, window_d;
	phase_t           phase_q, phase_d;

	// Decode of the current tick.
	logic               accept;
	logic               release_tick;
	logic               rd_hit;
	logic               wr_hit;
	logic               in_range;
	logic               tick_gv;
	logic [GRANT_W-1:0] tick_gi;

	// Stage 1 waits for the RAM read data; the output register holds the beat.
	logic               valid_s1;
	logic               gv_s1;
	logic [GRANT_W-1:0] gi_s1;
	logic               rack_s1;
	logic               wack_s1;
	logic               rd_zero_s1;
	logic               move_s1;

	logic               out_valid_q;
	logic               gv_q;
	logic [GRANT_W-1:0] gi_q;
	logic               rack_q;
	logic               wack_q;
	logic [DATA_W-1:0]  rdata_q;

	logic [DATA_W-1:0]  ram_rdata;

	// A new tick enters when stage 1 is empty or drains this cycle.
	assign move_s1      = valid_s1 && (!out_valid_q || rsp_ch.ready);
	assign req_ch.ready = !valid_s1 || move_s1;
	assign accept       = req_ch.valid && req_ch.ready;

	// After a served request, or once the window is used up, the tick is a
	// release tick: the grant drops and the pointer moves on.
	assign release_tick = (phase_q != PHASE_IDLE) || (window_q >= WIN_W'(POLL_WINDOW));
	assign rd_hit       = !release_tick && req_ch.read_requests[ptr_q];
	assign wr_hit       = !release_tick && !rd_hit && req_ch.write_requests[ptr_q];
	assign in_range     = {1'b0, req_ch.address} < (ADDR_W + 1)'(STORE_WORDS);

	// Next-state logic for the turn.
	always_comb begin
		ptr_d    = ptr_q;
		window_d = window_q;
		phase_d  = phase_q;
		if (release_tick) begin
			ptr_d    = (ptr_q == PTR_W'(REQUESTER_COUNT - 1)) ? '0 : ptr_q + PTR_W'(1);
			window_d = '0;
			phase_d  = PHASE_IDLE;
		end else if (rd_hit) begin
			phase_d = PHASE_READ;
		end else if (wr_hit) begin
			phase_d = PHASE_WRITE;
		end else begin
			window_d = window_q + WIN_W'(1);
		end
	end

	// Outputs of the turn logic for this tick.
	always_comb begin
		tick_gv = !release_tick;
		tick_gi = release_tick ? '0 : GRANT_W'(ptr_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q    <= '0;
			window_q <= '0;
			phase_q  <= PHASE_IDLE;
		end else if (accept) begin
			ptr_q    <= ptr_d;
			window_q <= window_d;
			phase_q  <= phase_d;
		end
	end

	// The RAM read happens in the accept cycle, so its registered data is
	// ready in stage 1. No new read is issued while stage 1 still waits,
	// which keeps the read data steady until it moves on. A write lands at
	// the accept edge, so a read in the next tick already sees it.
	rrpm_word_ram u_ram (
		.clk   (clk),
		.we    (accept && wr_hit && in_range),
		.re    (accept && rd_hit && in_range),
		.addr  (req_ch.address[MEM_AW-1:0]),
		.wdata (req_ch.write_data),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (move_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			gv_s1      <= tick_gv;
			gi_s1      <= tick_gi;
			rack_s1    <= rd_hit;
			wack_s1    <= wr_hit;
			rd_zero_s1 <= !(rd_hit && in_range);
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (move_s1) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move_s1) begin
			gv_q    <= gv_s1;
			gi_q    <= gi_s1;
			rack_q  <= rack_s1;
			wack_q  <= wack_s1;
			rdata_q <= rd_zero_s1 ? '0 : ram_rdata;
		end
	end

	assign rsp_ch.valid       = out_valid_q;
	assign rsp_ch.grant_valid = gv_q;
	assign rsp_ch.grant_index = gi_q;
	assign rsp_ch.read_ack    = rack_q;
	assign rsp_ch.write_ack   = wack_q;
	assign rsp_ch.read_data   = rdata_q;

endmodule
